/* src/pctd_pkg.sv */
// Shared constants for the prefix code table decoder.
package pctd_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int MAX_CODE_BITS_DEF = 32;
    localparam int BYTE_BITS         = 8;
    localparam int ENTRY_CODE_BITS   = 32;
    localparam int ENTRY_LEN_BITS    = 6;
    localparam int SYMBOL_BITS       = 8;

    localparam logic       REQ_LOAD = 1'b0;
    localparam logic       REQ_DATA = 1'b1;

    localparam logic [1:0] STATUS_SYMBOL   = 2'd0;
    localparam logic [1:0] STATUS_TRUNC    = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

endpackage

/* src/pctd_ram.sv */
// Generic single-port RAM with registered read.
module pctd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* src/prefix_code_table_decoder.sv */
// Prefix code table decoder: table RAM scan per input bit, pending and output result registers.
//
// Input channel (s_*): a load transaction (req_type 0) writes one table slot
// (code, length, symbol); a slot past the table size is dropped.
// A data transaction (req_type 1) carries a byte whose low valid_bits bits
// (saturated to 8) are decoded most significant bit first.
// For each bit the accumulator grows by one bit and the table RAM is scanned
// from slot 0 upward, one slot per cycle through the single RAM read port,
// until the first hit or the end of the table.
// Output channel (m_*): one result per decoded code or error: symbol, status
// (0 symbol, 1 stream ended inside a code, 2 code reached MAX_CODE_BITS),
// last_of_run on the final result of an input transaction. One result is
// held back until the next one or the end of the byte is known.
// s_ready is high only between data transactions. A stalled receiver holds
// the output register and the decoder waits when it has a second result.
// Reset empties the table (per-slot valid flops) and clears the accumulator.
module prefix_code_table_decoder #(
    parameter int TABLE_ENTRIES = pctd_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_CODE_BITS = pctd_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_req_type,
    input  logic [pctd_pkg::BYTE_BITS-1:0]    s_data_byte,
    input  logic [3:0]                        s_valid_bits,
    input  logic                              s_last_byte,
    input  logic [7:0]                        s_entry_index,
    input  logic [pctd_pkg::ENTRY_CODE_BITS-1:0] s_entry_code,
    input  logic [pctd_pkg::ENTRY_LEN_BITS-1:0]  s_entry_length,
    input  logic [pctd_pkg::SYMBOL_BITS-1:0]  s_entry_symbol,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pctd_pkg::SYMBOL_BITS-1:0]  m_symbol,
    output logic [1:0]                        m_status,
    output logic                              m_last_of_run
);
    import pctd_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int LW = $clog2(MAX_CODE_BITS + 1);
    localparam int CW = (MAX_CODE_BITS > ENTRY_CODE_BITS) ? MAX_CODE_BITS : ENTRY_CODE_BITS;
    localparam int DW = ENTRY_CODE_BITS + ENTRY_LEN_BITS + SYMBOL_BITS;
    localparam int MW = (LW > ENTRY_LEN_BITS) ? LW : ENTRY_LEN_BITS;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SHIFT, ST_SCAN, ST_PUSH, ST_FINISH
    } state_t;

    state_t                   state_reg;
    logic [BYTE_BITS-1:0]     byte_reg;
    logic [3:0]               nbits_reg;
    logic                     last_reg;
    logic [MAX_CODE_BITS-1:0] acc_reg;
    logic [LW-1:0]            alen_reg;
    logic [AW:0]              scan_cnt_reg;
    logic                     rd_ok_reg;
    logic [AW-1:0]            rd_addr_reg;
    logic                     rd_valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic                     pend_valid_reg;
    logic [SYMBOL_BITS-1:0]   pend_sym_reg;
    logic [1:0]               pend_st_reg;
    logic [SYMBOL_BITS-1:0]   new_sym_reg;
    logic [1:0]               new_st_reg;
    logic                     m_valid_reg;
    logic [SYMBOL_BITS-1:0]   m_symbol_reg;
    logic [1:0]               m_status_reg;
    logic                     m_last_reg;

    logic                     s_fire;
    logic                     load_we;
    logic [AW-1:0]            ram_addr;
    logic [DW-1:0]            ram_wdata;
    logic [DW-1:0]            ram_rdata;
    logic [ENTRY_CODE_BITS-1:0] rd_code;
    logic [ENTRY_LEN_BITS-1:0]  rd_len;
    logic [SYMBOL_BITS-1:0]   rd_sym;
    logic                     hit;
    logic                     out_free;
    logic                     m_load;
    logic [2:0]               bit_idx;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign load_we  = s_fire && (s_req_type == REQ_LOAD) &&
                      (32'(s_entry_index) < TABLE_ENTRIES);
    assign ram_addr = (state_reg == ST_IDLE) ? AW'(s_entry_index) : scan_cnt_reg[AW-1:0];
    assign ram_wdata = {s_entry_code, s_entry_length, s_entry_symbol};
    assign {rd_code, rd_len, rd_sym} = ram_rdata;

    assign hit = rd_ok_reg && rd_valid_reg &&
                 (MW'(rd_len) == MW'(alen_reg)) &&
                 (CW'(rd_code) == CW'(acc_reg));
    assign out_free = !m_valid_reg || m_ready;
    // the pending result moves to the output register this cycle
    assign m_load   = out_free && pend_valid_reg &&
                      ((state_reg == ST_PUSH) ||
                       (state_reg == ST_FINISH && !(last_reg && alen_reg != '0)));
    assign bit_idx  = 3'(nbits_reg - 4'd1);

    assign m_valid       = m_valid_reg;
    assign m_symbol      = m_symbol_reg;
    assign m_status      = m_status_reg;
    assign m_last_of_run = m_last_reg;

    pctd_ram #(
        .WIDTH(DW),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .aclk (aclk),
        .we   (load_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            acc_reg        <= '0;
            alen_reg       <= '0;
            valid_reg      <= '0;
            rd_ok_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            last_reg       <= 1'b0;
            nbits_reg      <= '0;
            scan_cnt_reg   <= '0;
        end else begin
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            rd_valid_reg <= valid_reg[ram_addr];
            unique case (state_reg)
                ST_IDLE: begin
                    if (load_we) begin
                        valid_reg[AW'(s_entry_index)] <= 1'b1;
                    end
                    if (s_fire && s_req_type == REQ_DATA) begin
                        byte_reg  <= s_data_byte;
                        nbits_reg <= (s_valid_bits > 4'(BYTE_BITS)) ? 4'(BYTE_BITS)
                                                                   : s_valid_bits;
                        last_reg  <= s_last_byte;
                        state_reg <= ST_SHIFT;
                    end
                end
                ST_SHIFT: begin
                    if (nbits_reg == 4'd0) begin
                        state_reg <= ST_FINISH;
                    end else begin
                        acc_reg      <= {acc_reg[MAX_CODE_BITS-2:0], byte_reg[bit_idx]};
                        alen_reg     <= alen_reg + LW'(1);
                        nbits_reg    <= nbits_reg - 4'd1;
                        scan_cnt_reg <= '0;
                        rd_ok_reg    <= 1'b0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    rd_ok_reg    <= (scan_cnt_reg < (AW+1)'(TABLE_ENTRIES));
                    rd_addr_reg  <= scan_cnt_reg[AW-1:0];
                    scan_cnt_reg <= scan_cnt_reg + (AW+1)'(1);
                    if (hit) begin
                        new_sym_reg <= rd_sym;
                        new_st_reg  <= STATUS_SYMBOL;
                        acc_reg     <= '0;
                        alen_reg    <= '0;
                        state_reg   <= ST_PUSH;
                    end else if (rd_ok_reg && rd_addr_reg == AW'(TABLE_ENTRIES - 1)) begin
                        // full scan without a hit
                        if (alen_reg == LW'(MAX_CODE_BITS)) begin
                            new_sym_reg <= '0;
                            new_st_reg  <= STATUS_TOO_LONG;
                            acc_reg     <= '0;
                            alen_reg    <= '0;
                            state_reg   <= ST_PUSH;
                        end else begin
                            state_reg <= ST_SHIFT;
                        end
                    end
                end
                ST_PUSH: begin
                    // hold the newest result until the next one proves it is not last
                    if (!pend_valid_reg) begin
                        pend_valid_reg <= 1'b1;
                        pend_sym_reg   <= new_sym_reg;
                        pend_st_reg    <= new_st_reg;
                        state_reg      <= ST_SHIFT;
                    end else if (out_free) begin
                        m_symbol_reg <= pend_sym_reg;
                        m_status_reg <= pend_st_reg;
                        m_last_reg   <= 1'b0;
                        pend_sym_reg <= new_sym_reg;
                        pend_st_reg  <= new_st_reg;
                        state_reg    <= ST_SHIFT;
                    end
                end
                ST_FINISH: begin
                    if (last_reg && alen_reg != '0) begin
                        new_sym_reg <= '0;
                        new_st_reg  <= STATUS_TRUNC;
                        acc_reg     <= '0;
                        alen_reg    <= '0;
                        last_reg    <= 1'b0;
                        state_reg   <= ST_PUSH;
                    end else if (!pend_valid_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (out_free) begin
                        m_symbol_reg   <= pend_sym_reg;
                        m_status_reg   <= pend_st_reg;
                        m_last_reg     <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
